FILE: hdl/ubtrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit/receive queue package
// Depths, widths, event codes and result types shared by the queue core.
// ----------------------------------------------------------------------------
package ubtrq_pkg;

  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 64;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int PTR_W    = 16;
  localparam int FILL_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 3;
  localparam int RES_W    = 22;
  localparam int OUT_TW   = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT  = 3'd0,
    MODE_GET  = 3'd1,
    MODE_RECV = 3'd2,
    MODE_TXE  = 3'd3,
    MODE_TXC  = 3'd4
  } mode_e;

  typedef struct packed {
    logic              from_rx;
    logic              from_tx;
    logic              rx_empty;
    logic              rejected;
    logic              busy;
    logic              empty_arm;
    logic              complete_arm;
    logic [BYTE_W-1:0] marker;
  } pend_t;

  typedef struct packed {
    logic              complete_arm;
    logic              empty_arm;
    logic              busy;
    logic [BYTE_W-1:0] send_byte;
    logic              send_valid;
    logic              rejected;
    logic              rx_empty;
    logic [BYTE_W-1:0] read_byte;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/ubtrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ubtrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/uart_buffered_tx_rx_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART buffered transmit/receive queue core
// Transmit and receive ring buffers with interrupt-style event sequencing.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: mode[2:0]; tdata: data_byte[7:0]
// m_axis    out        tdata: read_byte, flags, send_byte, status bits
// cfg       in         data: empty_marker[7:0]
//
// An event is decoded and its ring RAM read issued in the transfer cycle.
// The registered RAM data joins the result in the output register.
// Sustained rate is one event per clock while the output is not stalled.
// Reset clears pointers, fill count, flags and the marker; ring contents stay undefined.
// A stalled output holds the pending stage, which then stops input transfers.
module uart_buffered_tx_rx_queue_core
  import ubtrq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,   // data_byte[7:0]
  input  wire logic [MODE_W-1:0]  s_axis_tuser_i,   // mode[2:0]
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // read_byte[7:0], rx_was_empty[8], put_rejected[9], send_valid[10],
  // send_byte[18:11], tx_busy[19], empty_event_armed[20],
  // complete_event_armed[21], zero[23:22]
  output logic [OUT_TW-1:0]       m_axis_tdata_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [BYTE_W-1:0]  cfg_data_i
);

  logic [PTR_W-1:0]  tx_wptr_q, tx_wptr_d, tx_rptr_q, tx_rptr_d;
  logic [PTR_W-1:0]  rx_wptr_q, rx_wptr_d, rx_rptr_q, rx_rptr_d;
  logic [TX_AW-1:0]  tx_wslot_q, tx_wslot_d, tx_rslot_q, tx_rslot_d;
  logic [RX_AW-1:0]  rx_wslot_q, rx_wslot_d, rx_rslot_q, rx_rslot_d;
  logic [FILL_W-1:0] tx_fill_q, tx_fill_d;
  logic              busy_q, busy_d, earm_q, earm_d, carm_q, carm_d;
  logic [BYTE_W-1:0] marker_q;
  logic              pend_valid_q;
  pend_t             pend_q, pend_d;
  logic              out_valid_q;
  res_t              res_q, res_d;

  logic              in_xfer, out_move;
  logic              tx_we, tx_re, rx_we, rx_re;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  mode_e             mode;

  assign mode            = mode_e'(s_axis_tuser_i);
  assign out_move        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !pend_valid_q || out_move;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  ubtrq_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wslot_q),
    .wdata_i (s_axis_tdata_i),
    .re_i    (tx_re),
    .raddr_i (tx_rslot_q),
    .rdata_o (tx_rdata)
  );

  ubtrq_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wslot_q),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rx_re),
    .raddr_i (rx_rslot_q),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    tx_wptr_d  = tx_wptr_q;
    tx_rptr_d  = tx_rptr_q;
    rx_wptr_d  = rx_wptr_q;
    rx_rptr_d  = rx_rptr_q;
    tx_wslot_d = tx_wslot_q;
    tx_rslot_d = tx_rslot_q;
    rx_wslot_d = rx_wslot_q;
    rx_rslot_d = rx_rslot_q;
    tx_fill_d  = tx_fill_q;
    busy_d     = busy_q;
    earm_d     = earm_q;
    carm_d     = carm_q;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    pend_d     = '0;
    pend_d.marker = marker_q;
    if (in_xfer) begin
      case (mode)
        MODE_PUT: begin
          if (tx_fill_q >= FILL_W'(TX_DEPTH)) begin
            pend_d.rejected = 1'b1;
          end else begin
            tx_we     = 1'b1;
            tx_wptr_d = tx_wptr_q + 1'b1;
            tx_fill_d = tx_fill_q + 1'b1;
            busy_d    = 1'b1;
            earm_d    = 1'b1;
            if (tx_wptr_q == '1 || tx_wslot_q == TX_AW'(TX_DEPTH - 1)) begin
              tx_wslot_d = '0;
            end else begin
              tx_wslot_d = tx_wslot_q + 1'b1;
            end
          end
        end
        MODE_GET: begin
          if (rx_rptr_q == rx_wptr_q) begin
            pend_d.rx_empty = 1'b1;
          end else begin
            rx_re          = 1'b1;
            pend_d.from_rx = 1'b1;
            rx_rptr_d      = rx_rptr_q + 1'b1;
            if (rx_rptr_q == '1 || rx_rslot_q == RX_AW'(RX_DEPTH - 1)) begin
              rx_rslot_d = '0;
            end else begin
              rx_rslot_d = rx_rslot_q + 1'b1;
            end
          end
        end
        MODE_RECV: begin
          rx_we     = 1'b1;
          rx_wptr_d = rx_wptr_q + 1'b1;
          if (rx_wptr_q == '1 || rx_wslot_q == RX_AW'(RX_DEPTH - 1)) begin
            rx_wslot_d = '0;
          end else begin
            rx_wslot_d = rx_wslot_q + 1'b1;
          end
        end
        MODE_TXE: begin
          if (earm_q) begin
            if (tx_wptr_q == tx_rptr_q) begin
              earm_d    = 1'b0;
              carm_d    = 1'b1;
              tx_fill_d = '0;
            end else begin
              tx_re          = 1'b1;
              pend_d.from_tx = 1'b1;
              tx_rptr_d      = tx_rptr_q + 1'b1;
              if (tx_fill_q != '0) begin
                tx_fill_d = tx_fill_q - 1'b1;
              end
              if (tx_rptr_q == '1 || tx_rslot_q == TX_AW'(TX_DEPTH - 1)) begin
                tx_rslot_d = '0;
              end else begin
                tx_rslot_d = tx_rslot_q + 1'b1;
              end
            end
          end
        end
        MODE_TXC: begin
          if (carm_q) begin
            busy_d = 1'b0;
            carm_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    pend_d.busy         = busy_d;
    pend_d.empty_arm    = earm_d;
    pend_d.complete_arm = carm_d;
  end

  always_comb begin
    res_d              = '0;
    res_d.rx_empty     = pend_q.rx_empty;
    res_d.rejected     = pend_q.rejected;
    res_d.send_valid   = pend_q.from_tx;
    res_d.busy         = pend_q.busy;
    res_d.empty_arm    = pend_q.empty_arm;
    res_d.complete_arm = pend_q.complete_arm;
    if (pend_q.from_rx) begin
      res_d.read_byte = rx_rdata;
    end else if (pend_q.rx_empty) begin
      res_d.read_byte = pend_q.marker;
    end
    if (pend_q.from_tx) begin
      res_d.send_byte = tx_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wptr_q    <= '0;
      tx_rptr_q    <= '0;
      rx_wptr_q    <= '0;
      rx_rptr_q    <= '0;
      tx_wslot_q   <= '0;
      tx_rslot_q   <= '0;
      rx_wslot_q   <= '0;
      rx_rslot_q   <= '0;
      tx_fill_q    <= '0;
      busy_q       <= 1'b0;
      earm_q       <= 1'b0;
      carm_q       <= 1'b0;
      marker_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tx_wptr_q  <= tx_wptr_d;
      tx_rptr_q  <= tx_rptr_d;
      rx_wptr_q  <= rx_wptr_d;
      rx_rptr_q  <= rx_rptr_d;
      tx_wslot_q <= tx_wslot_d;
      tx_rslot_q <= tx_rslot_d;
      rx_wslot_q <= rx_wslot_d;
      rx_rslot_q <= rx_rslot_d;
      tx_fill_q  <= tx_fill_d;
      busy_q     <= busy_d;
      earm_q     <= earm_d;
      carm_q     <= carm_d;
      if (cfg_valid_i && cfg_ready_o) begin
        marker_q <= cfg_data_i;
      end
      if (in_xfer) begin
        pend_valid_q <= 1'b1;
      end else if (out_move) begin
        pend_valid_q <= 1'b0;
      end
      if (out_move) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_q <= pend_d;
    end
    if (out_move && pend_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TW - RES_W){1'b0}}, res_q};

  a_fill_tracks_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_fill_q == FILL_W'(tx_wptr_q - tx_rptr_q))
    else $error("transmit fill count disagrees with pointers");

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_fill_q <= FILL_W'(TX_DEPTH))
    else $error("transmit fill count above ring depth");

  a_pend_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !out_move |=> pend_valid_q && $stable(pend_q))
    else $error("pending result lost while output stalled");

  a_send_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.send_valid |-> res_q.empty_arm && !res_q.rx_empty)
    else $error("byte sent without empty event armed");

endmodule
`default_nettype wire
